// ===== design/tdpc_pkg.sv =====
`default_nettype none

package tdpc_pkg;

  // Field widths
  localparam int unsigned NUMBER_BITS = 31;
  localparam int unsigned SLOT_BITS   = 8;
  localparam int unsigned BUDGET_BITS = 16;
  localparam int unsigned VALUE_BITS  = 32;

  // Divisor never passes floor(sqrt(2^NUMBER_BITS)) + 1
  localparam int unsigned DIV_BITS = NUMBER_BITS / 2 + 1;
  localparam int unsigned SQ_BITS  = 2 * DIV_BITS;
  // Bit counter of the remainder unit, holds NUMBER_BITS itself
  localparam int unsigned CNT_BITS = $clog2(NUMBER_BITS + 1);

  // Stream word widths, padded to whole bytes
  localparam int unsigned IN_RAW_BITS  = NUMBER_BITS + SLOT_BITS;
  localparam int unsigned IN_TDATA_W   = ((IN_RAW_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_RAW_BITS = SLOT_BITS + 2 + VALUE_BITS;
  localparam int unsigned OUT_TDATA_W  = ((OUT_RAW_BITS + 7) / 8) * 8;

  localparam logic [BUDGET_BITS-1:0] BUDGET_RESET = '1;

  typedef enum logic [1:0] {
    V_NOT_PRIME = 2'd0,
    V_PRIME     = 2'd1,
    V_TIMEOUT   = 2'd2
  } verdict_e;

  // Status of the shared remainder unit
  typedef struct packed {
    logic done;
    logic zero;
  } rem_stat_t;

  // One finished result
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    verdict_e              verdict;
    logic [SLOT_BITS-1:0]  slot;
  } result_t;

endpackage

`default_nettype wire

// ===== design/tdpc_rem_unit.sv =====
`default_nettype none

module tdpc_rem_unit
  import tdpc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [NUMBER_BITS-1:0] dividend_i,
  input  wire logic [DIV_BITS-1:0]    divisor_i,
  output rem_stat_t                   stat_o
);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CNT_BITS-1:0]    cnt_q, cnt_d;
  logic [NUMBER_BITS-1:0] dvd_q, dvd_d;
  logic [DIV_BITS-1:0]    dvs_q, dvs_d;
  logic [DIV_BITS-1:0]    rem_q, rem_d;
  logic [DIV_BITS:0]      trial;
  logic [DIV_BITS:0]      diff;

  // Bring down one dividend bit and subtract the divisor if it fits
  always_comb begin
    trial = {rem_q, dvd_q[NUMBER_BITS-1]};
    diff  = trial - {1'b0, dvs_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CNT_BITS'(NUMBER_BITS);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[NUMBER_BITS-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[DIV_BITS-1:0];
      end else begin
        rem_d = trial[DIV_BITS-1:0];
      end
      cnt_d = cnt_q - CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.zero = (rem_q == '0);

  // Done follows the last step of a busy run
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("remainder done without a run");

  // A fresh run is only started while idle
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("remainder start while busy");

endmodule

`default_nettype wire

// ===== design/tdpc_ctrl.sv =====
`default_nettype none

module tdpc_ctrl
  import tdpc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   item_valid_i,
  output logic                        item_ready_o,
  input  wire logic [NUMBER_BITS-1:0] number_i,
  input  wire logic [SLOT_BITS-1:0]   slot_i,
  input  wire logic [BUDGET_BITS-1:0] budget_i,
  output logic                        res_valid_o,
  input  wire logic                   res_ready_i,
  output result_t                     res_o,
  output logic                        rem_start_o,
  output logic [NUMBER_BITS-1:0]      rem_dividend_o,
  output logic [DIV_BITS-1:0]         rem_divisor_o,
  input  wire rem_stat_t              rem_stat_i
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CHECK  = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_DONE   = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  verdict_e               verdict_q, verdict_d;
  logic [NUMBER_BITS-1:0] num_q, num_d;
  logic [SLOT_BITS-1:0]   slot_q, slot_d;
  logic [DIV_BITS-1:0]    div_q, div_d;
  logic [SQ_BITS-1:0]     sq_q, sq_d;
  logic [BUDGET_BITS-1:0] tests_q, tests_d;
  logic [VALUE_BITS-1:0]  num_ext;

  // Sequence the divisor loop
  always_comb begin
    state_d     = state_q;
    verdict_d   = verdict_q;
    num_d       = num_q;
    slot_d      = slot_q;
    div_d       = div_q;
    sq_d        = sq_q;
    tests_d     = tests_q;
    rem_start_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          num_d   = number_i;
          slot_d  = slot_i;
          div_d   = DIV_BITS'(2);
          sq_d    = SQ_BITS'(4);
          tests_d = '0;
          if (number_i < NUMBER_BITS'(2)) begin
            verdict_d = V_NOT_PRIME;
            state_d   = ST_DONE;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sq_q > SQ_BITS'(num_q)) begin
          verdict_d = V_PRIME;
          state_d   = ST_DONE;
        end else if (tests_q >= budget_i) begin
          verdict_d = V_TIMEOUT;
          state_d   = ST_DONE;
        end else begin
          rem_start_o = 1'b1;
          state_d     = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (rem_stat_i.done) begin
          tests_d = tests_q + BUDGET_BITS'(1);
          if (rem_stat_i.zero) begin
            verdict_d = V_NOT_PRIME;
            state_d   = ST_DONE;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            div_d   = div_q + DIV_BITS'(1);
            sq_d    = sq_q + SQ_BITS'({div_q, 1'b1});
            state_d = ST_CHECK;
          end
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      verdict_q <= V_NOT_PRIME;
      tests_q   <= '0;
    end else begin
      state_q   <= state_d;
      verdict_q <= verdict_d;
      tests_q   <= tests_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    slot_q <= slot_d;
    div_q  <= div_d;
    sq_q   <= sq_d;
  end

  assign item_ready_o   = (state_q == ST_IDLE);
  assign res_valid_o    = (state_q == ST_DONE);
  assign rem_dividend_o = num_q;
  assign rem_divisor_o  = div_q;

  // Build the signed answer from the verdict
  assign num_ext = VALUE_BITS'(num_q);
  always_comb begin
    res_o.slot    = slot_q;
    res_o.verdict = verdict_q;
    case (verdict_q)
      V_PRIME:     res_o.value = num_ext;
      V_NOT_PRIME: res_o.value = VALUE_BITS'(0) - num_ext;
      default:     res_o.value = '1;
    endcase
  end

  // The test count never runs past the budget while a number is in work
  a_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK || state_q == ST_DIVIDE) |-> (tests_q <= budget_i))
    else $error("test count beyond budget");

  // A prime verdict is only given once the divisor square passed the number
  a_prime_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && verdict_q == V_PRIME) |-> (sq_q > SQ_BITS'(num_q)))
    else $error("prime verdict before square bound");

endmodule

`default_nettype wire

// ===== design/trial_division_prime_check_core.sv =====
`default_nettype none

// Trial-division primality checker.
// Input words arrive on s_axis: a 31-bit number and an 8-bit slot tag.
// Each word yields exactly one output word on m_axis: the slot tag, a verdict
// (0 not prime, 1 prime, 2 timed out) and a signed value (+n, -n or -1).
// The cfg channel writes the 16-bit budget of divisor tests per number;
// it is always ready. The user must write it only between items; the
// block itself does not enforce this. One number is in work at a time;
// s_axis_tready_o is high only while the sequencer is idle. Numbers below
// two go straight to a result with no divisor test. Otherwise each divisor
// test runs a check state, one remainder step per dividend bit in the
// shared remainder unit, and a divide state that takes its result.
// The finished word sits in an output register; a new number is accepted
// while it waits, but the next result stalls in the sequencer until the
// receiver takes the old one.
// Reset empties the output register, idles the sequencer and sets the
// budget to 65535.

module trial_division_prime_check_core
  import tdpc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // [30:0] number, [38:31] slot, [39] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // [7:0] slot_out, [9:8] verdict, [41:10] signed_value, [47:42] zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [BUDGET_BITS-1:0] cfg_data_i
);

  logic [BUDGET_BITS-1:0] budget_q, budget_d;
  logic                   out_valid_q, out_valid_d;
  result_t                out_res_q, out_res_d;
  logic                   res_valid;
  logic                   res_ready;
  result_t                res;
  logic                   rem_start;
  logic [NUMBER_BITS-1:0] rem_dividend;
  logic [DIV_BITS-1:0]    rem_divisor;
  rem_stat_t              rem_stat;

  tdpc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (s_axis_tvalid_i),
    .item_ready_o   (s_axis_tready_o),
    .number_i       (s_axis_tdata_i[NUMBER_BITS-1:0]),
    .slot_i         (s_axis_tdata_i[NUMBER_BITS +: SLOT_BITS]),
    .budget_i       (budget_q),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .rem_start_o    (rem_start),
    .rem_dividend_o (rem_dividend),
    .rem_divisor_o  (rem_divisor),
    .rem_stat_i     (rem_stat)
  );

  tdpc_rem_unit u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dividend),
    .divisor_i  (rem_divisor),
    .stat_o     (rem_stat)
  );

  // Take budget writes at any time
  assign cfg_ready_o = 1'b1;
  always_comb begin
    budget_d = budget_q;
    if (cfg_valid_i) begin
      budget_d = cfg_data_i;
    end
  end

  // Load the output register when it is empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready_i;
  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_res_d   = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q    <= BUDGET_RESET;
      out_valid_q <= 1'b0;
    end else begin
      budget_q    <= budget_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({out_res_q.value, out_res_q.verdict, out_res_q.slot});

  // A result may only be loaded when the register has room
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !(res_valid && res_ready))
    else $error("output word overwritten");

endmodule

`default_nettype wire

// ===== tb/trial_division_prime_check_core_tb.sv =====
`timescale 1ns / 100ps

module trial_division_prime_check_core_tb;
  import tdpc_pkg::*;

  localparam int unsigned COST_CAP      = 250;        // most divisor tests per random number
  localparam int unsigned CYCLE_LIMIT   = 5_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;

  // Expected verdicts of the primality checker, oldest first
  class prime_scoreboard;
    logic [BUDGET_BITS-1:0] budget;
    // Copy of the checker state after the last number
    logic [NUMBER_BITS-1:0] last_number;
    logic [15:0]            last_divisor;
    logic [15:0]            last_tests;
    logic [NUMBER_BITS-1:0] last_remainder;
    logic [SLOT_BITS-1:0]   last_slot;
    result_t                pending_results[$];
    int unsigned            errors;

    function new();
      budget         = BUDGET_RESET;
      last_number    = '0;
      last_divisor   = '0;
      last_tests     = '0;
      last_remainder = '0;
      last_slot      = '0;
      errors         = 0;
    endfunction

    function void set_budget(logic [BUDGET_BITS-1:0] value);
      budget = value;
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    // Try divisors 2, 3, ... while d*d <= n; check the budget before each test
    function void trial_divide(input longint unsigned n, output verdict_e verdict,
                               output longint unsigned tests, output longint unsigned d,
                               output longint unsigned rem);
      d     = 2;
      tests = 0;
      rem   = 0;
      if (n < 2) begin
        verdict = V_NOT_PRIME;
      end else begin
        verdict = V_PRIME;
        while (d * d <= n) begin
          if (tests >= budget) begin
            verdict = V_TIMEOUT;
            break;
          end
          rem = n % d;
          tests++;
          if (rem == 0) begin
            verdict = V_NOT_PRIME;
            break;
          end
          d++;
        end
      end
    endfunction

    function longint unsigned tests_needed(logic [NUMBER_BITS-1:0] number);
      verdict_e          verdict;
      longint unsigned   tests, d, rem;
      trial_divide(number, verdict, tests, d, rem);
      return tests;
    endfunction

    // Work out the result of an accepted number and queue it
    function void note_number(logic [NUMBER_BITS-1:0] number, logic [SLOT_BITS-1:0] slot);
      verdict_e          verdict;
      longint unsigned   tests, d, rem;
      result_t           res;
      trial_divide(number, verdict, tests, d, rem);
      res.slot    = slot;
      res.verdict = verdict;
      case (verdict)
        V_PRIME:     res.value = VALUE_BITS'(number);
        V_NOT_PRIME: res.value = VALUE_BITS'(0) - VALUE_BITS'(number);
        default:     res.value = '1;
      endcase
      pending_results.push_back(res);
      last_number    = number;
      last_slot      = slot;
      last_divisor   = d[15:0];
      last_tests     = tests[15:0];
      last_remainder = rem[NUMBER_BITS-1:0];
    endfunction

    // Compare one output word with the oldest expectation
    function void check_word(logic [OUT_TDATA_W-1:0] word);
      result_t got, want;
      got = result_t'(word[OUT_RAW_BITS-1:0]);
      if (pending_results.size() == 0) begin
        $error("result word %h with no number outstanding", word);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.slot !== want.slot) begin
        $error("slot_out: expected %0d, got %0d", want.slot, got.slot);
        errors++;
      end
      if (got.verdict !== want.verdict) begin
        $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
        errors++;
      end
      if (got.value !== want.value) begin
        $error("signed_value: expected %0d, got %0d",
               $signed(want.value), $signed(got.value));
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [BUDGET_BITS-1:0] cfg_data_i = '0;

  logic                   steady_flow = 1'b0;
  int unsigned            cycle_count = 0;
  prime_scoreboard        sb = new();

  trial_division_prime_check_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Sample every handshake at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      sb.set_budget(cfg_data_i);
    end
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      sb.note_number(s_axis_tdata_i[NUMBER_BITS-1:0],
                     s_axis_tdata_i[NUMBER_BITS +: SLOT_BITS]);
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_word(m_axis_tdata_o);
    end
  end

  // Stall the result side at random unless the flow is steady
  always @(negedge clk_i) begin
    m_axis_tready_i <= steady_flow || ($urandom_range(99) >= 30);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Present one word and hold it until taken; called and left at a falling edge
  task automatic send_number(input logic [NUMBER_BITS-1:0] number,
                             input logic [SLOT_BITS-1:0] slot);
    if (!steady_flow && $urandom_range(99) < 30) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_TDATA_W'({slot, number});
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // Drop valid and hold off until every result has come back
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_budget(input logic [BUDGET_BITS-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mix small numbers, full-width noise, composites and numbers near the top
  function automatic logic [NUMBER_BITS-1:0] random_number();
    int unsigned     kind;
    longint unsigned factor;
    longint unsigned value;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      value = $urandom_range(0, 4095);
    end else if (kind < 50) begin
      value = $urandom;
    end else if (kind < 70) begin
      factor = $urandom_range(2, 600);
      value  = factor * $urandom_range(2, 32'h7fff_ffff / factor);
    end else if (kind < 85) begin
      value = 32'h7fff_ffff - $urandom_range(0, 1000);
    end else begin
      value = $urandom_range(2, 200000);
    end
    return NUMBER_BITS'(value);
  endfunction

  // Send random numbers whose work stays within the cost cap, then drain
  task automatic random_burst(input int unsigned count);
    logic [NUMBER_BITS-1:0] number;
    repeat (count) begin
      do number = random_number(); while (sb.tests_needed(number) > COST_CAP);
      send_number(number, SLOT_BITS'($urandom_range(0, 255)));
    end
    drain_results();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset budget: tiny numbers, two and three, squares, top bits
    send_number(0, 0);
    send_number(1, 255);
    send_number(2, 8'h5a);
    send_number(3, 8'ha5);
    send_number(4, 1);
    send_number(5, 2);
    send_number(9, 3);
    send_number(49, 4);
    send_number(97, 5);
    send_number(31'h4000_0000, 6);
    send_number(31'h7fff_fffe, 7);
    send_number(1000003, 8);
    drain_results();

    // Zero budget: three still prime, one not prime, larger numbers time out
    write_budget(0);
    send_number(3, 9);
    send_number(4, 10);
    send_number(31'h7fff_ffff, 255);
    send_number(1, 11);
    drain_results();

    // Budget of one: met exactly by five, too small for nine
    write_budget(1);
    send_number(4, 12);
    send_number(5, 13);
    send_number(9, 14);
    drain_results();

    // Twenty-five needs four tests
    write_budget(3);
    send_number(25, 15);
    drain_results();
    write_budget(4);
    send_number(25, 16);
    drain_results();

    // Random phases across budget settings
    write_budget(16'hffff);
    random_burst(20);
    write_budget(BUDGET_BITS'($urandom_range(1, 40)));
    random_burst(20);
    write_budget(0);
    steady_flow = 1'b1;
    random_burst(15);
    steady_flow = 1'b0;
    write_budget(BUDGET_BITS'($urandom_range(0, 65535)));
    random_burst(20);
    write_budget(2);
    random_burst(10);
    write_budget(16'hffff);
    random_burst(15);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
